>>> rtl/rcf_pkg.sv
// Shared types, constants and the CRC helper for the raw Ethernet command framer.
package rcf_pkg;

  localparam logic [15:0] CRC_INIT  = 16'h1D0F;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  SYNC_BYTE = 8'h55;
  localparam logic [15:0] ETH_LEN_BASE = 16'd10;
  localparam int unsigned HDR_BYTES = 22;

  localparam logic ACTION_START   = 1'b0;
  localparam logic ACTION_PAYLOAD = 1'b1;

  localparam logic REG_DEST_MAC   = 1'b0;
  localparam logic REG_SOURCE_MAC = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] msg_id;
    logic [15:0] body_len;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  typedef enum logic {
    CMD_START,
    CMD_DATA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] msg_id;
    logic [15:0] body_len;
    logic [7:0]  data_byte;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HDR,
    BK_CRC_HI,
    BK_CRC_LO,
    BK_PAD
  } back_state_e;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/rcf_front.sv
// Front end: accepts requests, tracks the open frame and queues frame commands.
module rcf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rcf_pkg::in_item_t    in_data_i,
  input  rcf_pkg::fifo_status_t fifo_status_i,
  output logic                 push_o,
  output rcf_pkg::cmd_t        push_data_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        accept;
  logic        is_start;
  logic        is_live_data;

  assign in_ready_o   = !fifo_status_i.full;
  assign accept       = in_valid_i && in_ready_o;
  assign is_start     = (in_data_i.action == rcf_pkg::ACTION_START);
  assign is_live_data = (in_data_i.action == rcf_pkg::ACTION_PAYLOAD) && (remaining_q != 16'd0);

  assign push_o = accept && (is_start || is_live_data);

  always_comb begin
    push_data_o.kind      = is_start ? rcf_pkg::CMD_START : rcf_pkg::CMD_DATA;
    push_data_o.msg_id    = in_data_i.msg_id;
    push_data_o.body_len  = in_data_i.body_len;
    push_data_o.data_byte = in_data_i.payload_byte;
    push_data_o.last      = (remaining_q == 16'd1);
  end

  always_comb begin
    remaining_d = remaining_q;
    if (accept && is_start) begin
      remaining_d = in_data_i.body_len;
    end else if (accept && is_live_data) begin
      remaining_d = remaining_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else begin
      remaining_q <= remaining_d;
    end
  end

endmodule

>>> rtl/rcf_fifo.sv
// Two-entry command queue between the front end and the byte sequencer.
module rcf_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rcf_pkg::cmd_t         push_data_i,
  input  logic                  pop_i,
  output rcf_pkg::cmd_t         pop_data_o,
  output rcf_pkg::fifo_status_t status_o
);

  rcf_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push;
  logic          do_pop;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/rcf_back.sv
// Byte sequencer: emits header, payload, CRC and padding bytes through an output register.
module rcf_back #(
  parameter int unsigned MIN_PAYLOAD = 46
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [47:0]           dest_mac_i,
  input  logic [47:0]           source_mac_i,
  input  rcf_pkg::fifo_status_t fifo_status_i,
  input  rcf_pkg::cmd_t         cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rcf_pkg::out_item_t    out_data_o
);

  localparam int unsigned PAD_MAX = MIN_PAYLOAD - 10;
  localparam int unsigned CNT_W   =
    ($clog2(MIN_PAYLOAD + 1) > 5) ? $clog2(MIN_PAYLOAD + 1) : 5;

  rcf_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [15:0]          crc_q, crc_d;
  logic [15:0]          id_q, id_d;
  logic [15:0]          len_q, len_d;
  logic                 out_valid_q;
  rcf_pkg::out_item_t   out_data_q;

  logic                 advance;
  logic                 emit;
  rcf_pkg::out_item_t   emit_data;
  logic [4:0]           hdr_idx;
  logic [7:0]           hdr_byte;
  logic [15:0]          eth_len;
  logic                 pad_none;
  logic [CNT_W-1:0]     pad_count;
  logic [16:0]          pad_wide;

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] i);
    return mac[(5 - int'(i)) * 8 +: 8];
  endfunction

  assign advance   = !out_valid_q || out_ready_i;
  assign hdr_idx   = cnt_q[4:0];
  assign eth_len   = len_q + rcf_pkg::ETH_LEN_BASE;
  assign pad_none  = ({1'b0, len_q} >= 17'(PAD_MAX));
  assign pad_wide  = 17'(PAD_MAX) - {1'b0, len_q};
  assign pad_count = pad_wide[CNT_W-1:0];

  always_comb begin
    hdr_byte = 8'h00;
    if (hdr_idx < 5'd6) begin
      hdr_byte = mac_byte(dest_mac_i, hdr_idx[2:0]);
    end else if (hdr_idx < 5'd12) begin
      hdr_byte = mac_byte(source_mac_i, 3'(hdr_idx - 5'd6));
    end else begin
      case (hdr_idx)
        5'd12:   hdr_byte = eth_len[7:0];
        5'd13:   hdr_byte = eth_len[15:8];
        5'd14:   hdr_byte = rcf_pkg::SYNC_BYTE;
        5'd15:   hdr_byte = rcf_pkg::SYNC_BYTE;
        5'd16:   hdr_byte = id_q[15:8];
        5'd17:   hdr_byte = id_q[7:0];
        5'd18:   hdr_byte = len_q[7:0];
        5'd19:   hdr_byte = len_q[15:8];
        default: hdr_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    id_d      = id_q;
    len_d     = len_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    case (state_q)
      rcf_pkg::BK_IDLE: begin
        if (advance && !fifo_status_i.empty) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          if (cmd_i.kind == rcf_pkg::CMD_START) begin
            emit_data.frame_byte = dest_mac_i[47:40];
            id_d    = cmd_i.msg_id;
            len_d   = cmd_i.body_len;
            crc_d   = rcf_pkg::CRC_INIT;
            cnt_d   = CNT_W'(1);
            state_d = rcf_pkg::BK_HDR;
          end else begin
            emit_data.frame_byte = cmd_i.data_byte;
            crc_d = rcf_pkg::crc_feed(crc_q, cmd_i.data_byte);
            if (cmd_i.last) begin
              state_d = rcf_pkg::BK_CRC_HI;
            end
          end
        end
      end
      rcf_pkg::BK_HDR: begin
        if (advance) begin
          emit = 1'b1;
          emit_data.frame_byte = hdr_byte;
          if (hdr_idx >= 5'd16) begin
            crc_d = rcf_pkg::crc_feed(crc_q, hdr_byte);
          end
          cnt_d = cnt_q + CNT_W'(1);
          if (hdr_idx == 5'(rcf_pkg::HDR_BYTES - 1)) begin
            state_d = (len_q == 16'd0) ? rcf_pkg::BK_CRC_HI : rcf_pkg::BK_IDLE;
          end
        end
      end
      rcf_pkg::BK_CRC_HI: begin
        if (advance) begin
          emit = 1'b1;
          emit_data.frame_byte = crc_q[15:8];
          state_d = rcf_pkg::BK_CRC_LO;
        end
      end
      rcf_pkg::BK_CRC_LO: begin
        if (advance) begin
          emit = 1'b1;
          emit_data.frame_byte = crc_q[7:0];
          emit_data.frame_end  = pad_none;
          cnt_d   = pad_count;
          state_d = pad_none ? rcf_pkg::BK_IDLE : rcf_pkg::BK_PAD;
        end
      end
      rcf_pkg::BK_PAD: begin
        if (advance) begin
          emit = 1'b1;
          emit_data.frame_end = (cnt_q == CNT_W'(1));
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = rcf_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = rcf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcf_pkg::BK_IDLE;
      cnt_q       <= '0;
      crc_q       <= rcf_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    len_q <= len_d;
    if (advance && emit) begin
      out_data_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/raw_ethernet_command_framer_top.sv
// Top level of the raw Ethernet command framer.
//
// Requests enter on the in channel (valid/ready). A start request opens a frame;
// payload requests carry one byte each and are dropped when no frame is open.
// Frame bytes leave on the out channel (valid/ready), frame_end marking the last.
// The cfg port writes the destination MAC (index 0) and source MAC (index 1).
// A front end classifies each request and queues start and live payload requests
// in a two-entry command queue; a byte sequencer drains the queue and drives a
// registered output. The first byte of a frame passes through the queue and the
// output register after its start request is accepted. A start request yields
// 22 header bytes, plus 2 CRC bytes and MIN_PAYLOAD - 10 padding bytes when the
// payload is empty; each payload request yields one byte, so payload bytes stream
// at one per cycle while the receiver does not stall. The last payload byte is
// followed by 2 CRC bytes and up to MIN_PAYLOAD - 11 padding bytes.
// A stalled receiver holds the output register; the sequencer then waits, the
// queue fills and in_ready_o drops. Reset clears the MAC registers, the queue
// and the sequencer; no frame is open afterward.
module raw_ethernet_command_framer_top #(
  parameter int unsigned MIN_PAYLOAD = 46
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcf_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  logic [47:0]           dest_mac_q;
  logic [47:0]           source_mac_q;
  logic                  push;
  rcf_pkg::cmd_t         push_data;
  logic                  pop;
  rcf_pkg::cmd_t         pop_data;
  rcf_pkg::fifo_status_t fifo_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_mac_q   <= '0;
      source_mac_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rcf_pkg::REG_DEST_MAC) begin
        dest_mac_q <= cfg_data_i;
      end
      if (cfg_index_i == rcf_pkg::REG_SOURCE_MAC) begin
        source_mac_q <= cfg_data_i;
      end
    end
  end

  rcf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rcf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  rcf_back #(
    .MIN_PAYLOAD (MIN_PAYLOAD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dest_mac_i    (dest_mac_q),
    .source_mac_i  (source_mac_q),
    .fifo_status_i (fifo_status),
    .cmd_i         (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

`ifndef ASSERT_OFF
  a_fifo_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_status.full && fifo_status.empty))
    else $error("Command queue reports full and empty at once.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("Front end pushed into a full command queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("Sequencer popped an empty command queue.");
`endif

endmodule
